@@ rtl/ffrd_pkg.sv @@
// Shared types and constants for the flag frame receive deframer.
package ffrd_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] STUFF_MASK = 8'h20;
  localparam logic [7:0] SEQ_MASK   = 8'h40;
  localparam logic [7:0] CTRL_ZERO  = 8'h00;
  localparam int         SEQ_BIT    = 6;

  localparam logic [7:0] FLAG_RESET = 8'h7E;
  localparam logic [7:0] ESC_RESET  = 8'h7D;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FLAG = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ESC  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ADDR = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_FLAG = 3'd1,
    PH_ADDR = 3'd2,
    PH_CTRL = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] address_value;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       seq;
  } item_t;

  // One queue entry holds every result caused by one received byte.
  typedef struct packed {
    logic  two;
    item_t first;
    item_t second;
  } entry_t;

endpackage

@@ rtl/ffrd_front.sv @@
// Front end: header parser and escape removal, one byte per cycle while accepted.
module ffrd_front import ffrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       entry_push,
  output entry_t     entry
);

  phase_t     phase, phase_next;
  logic [7:0] control_seen, control_seen_next;
  logic       escape_pending, escape_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      control_seen   <= CTRL_ZERO;
      escape_pending <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      control_seen   <= control_seen_next;
      escape_pending <= escape_pending_next;
    end
  end

  always_comb begin
    logic  flush_v;
    logic  main_v;
    item_t flush_it;
    item_t main_it;
    logic  seq;

    seq                 = control_seen[SEQ_BIT];
    phase_next          = phase;
    control_seen_next   = control_seen;
    escape_pending_next = escape_pending;
    flush_v             = 1'b0;
    main_v              = 1'b0;
    flush_it            = '{data: cfg.escape_value, kind: KIND_DATA, seq: seq};
    main_it             = '{data: rx_byte, kind: KIND_DATA, seq: seq};

    case (phase)
      PH_FLAG: begin
        if (rx_byte == cfg.address_value) phase_next = PH_ADDR;
        else if (rx_byte != cfg.flag_value) phase_next = PH_IDLE;
      end
      PH_ADDR: begin
        if (rx_byte == CTRL_ZERO || rx_byte == SEQ_MASK) begin
          control_seen_next = rx_byte;
          phase_next        = PH_CTRL;
        end else begin
          phase_next = PH_FLAG;
        end
      end
      PH_CTRL: begin
        if (rx_byte == (cfg.address_value ^ control_seen)) begin
          phase_next          = PH_DATA;
          escape_pending_next = 1'b0;
        end else if (rx_byte == cfg.flag_value) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (escape_pending && rx_byte != cfg.flag_value &&
            (rx_byte == (cfg.flag_value ^ STUFF_MASK) ||
             rx_byte == (cfg.escape_value ^ STUFF_MASK))) begin
          main_v              = 1'b1;
          main_it.data        = rx_byte ^ STUFF_MASK;
          escape_pending_next = 1'b0;
        end else begin
          // An escape that is not followed by a stuffed byte goes out unchanged.
          flush_v             = escape_pending;
          escape_pending_next = 1'b0;
          if (rx_byte == cfg.flag_value) begin
            main_v       = 1'b1;
            main_it.data = CTRL_ZERO;
            main_it.kind = KIND_EOF;
            phase_next   = PH_IDLE;
          end else if (rx_byte == cfg.escape_value) begin
            escape_pending_next = 1'b1;
          end else begin
            main_v = 1'b1;
          end
        end
      end
      default: begin
        phase_next = (rx_byte == cfg.flag_value) ? PH_FLAG : PH_IDLE;
      end
    endcase

    entry_push = accept && (flush_v || main_v);
    if (flush_v) begin
      entry.first  = flush_it;
      entry.second = main_it;
      entry.two    = main_v;
    end else begin
      entry.first  = main_it;
      entry.second = main_it;
      entry.two    = 1'b0;
    end
  end

endmodule

@@ rtl/ffrd_fifo.sv @@
// Short queue of result entries between the parser and the output side.
module ffrd_fifo import ffrd_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_entry,
  input  logic   rd_en,
  output entry_t rd_entry,
  output logic   fifo_empty,
  output logic   fifo_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign fifo_empty = (count == '0);
  assign fifo_full  = (count == CNT_W'(DEPTH));
  assign rd_entry   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/ffrd_back.sv @@
// Output side: hands out the one or two results of each queued entry in order.
module ffrd_back import ffrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       fifo_empty,
  output logic       fifo_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       item_kind,
  output logic       seq_bit,
  output logic       last_of_run
);

  logic  second_sel;
  item_t cur;

  assign cur         = second_sel ? head.second : head.first;
  assign empty       = fifo_empty;
  assign out_byte    = cur.data;
  assign item_kind   = cur.kind;
  assign seq_bit     = cur.seq;
  assign last_of_run = second_sel || !head.two;
  assign fifo_pop    = pop && !fifo_empty && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_sel <= 1'b0;
    end else if (pop && !fifo_empty) begin
      second_sel <= !last_of_run;
    end
  end

endmodule

@@ rtl/flag_frame_receive_deframer.sv @@
// Top level of the flag frame receive deframer with its register port.
// Received bytes are pushed one per cycle: the parser hunts for the opening flag, checks
// address, control and header check, then strips escapes and queues the payload bytes and
// an end-of-frame marker. Every byte is parsed in the cycle it is pushed, so the input
// takes one byte per clock while the result queue (FIFO_DEPTH entries) has room; a byte
// that yields two results (a lone escape followed by another byte) needs two pops, and
// full rises when the queue fills. Results pop at one per clock while empty is low.
// Registers flag_value, escape_value and address_value sit at byte addresses 0, 4 and 8
// and should be written while no results are outstanding.
module flag_frame_receive_deframer import ffrd_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        item_kind,
  output logic        seq_bit,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 accept;
  logic                 entry_push;
  entry_t               entry;
  entry_t               head;
  logic                 fifo_empty;
  logic                 fifo_full;
  logic                 fifo_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value    <= FLAG_RESET;
      cfg.escape_value  <= ESC_RESET;
      cfg.address_value <= ADDR_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FLAG: cfg.flag_value    <= pwdata[7:0];
        REG_ESC:  cfg.escape_value  <= pwdata[7:0];
        REG_ADDR: cfg.address_value <= pwdata[7:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLAG: prdata = {24'b0, cfg.flag_value};
      REG_ESC:  prdata = {24'b0, cfg.escape_value};
      REG_ADDR: prdata = {24'b0, cfg.address_value};
      default:  prdata = '0;
    endcase
  end

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  ffrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .entry_push (entry_push),
    .entry      (entry)
  );

  ffrd_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (entry_push),
    .wr_entry   (entry),
    .rd_en      (fifo_pop),
    .rd_entry   (head),
    .fifo_empty (fifo_empty),
    .fifo_full  (fifo_full)
  );

  ffrd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fifo_empty  (fifo_empty),
    .fifo_pop    (fifo_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .item_kind   (item_kind),
    .seq_bit     (seq_bit),
    .last_of_run (last_of_run)
  );

endmodule
